>>> hw/rtl/vnsd_pkg.sv
// ----------------------------------------------------------------------------
// vnsd_pkg
// Shared types, constants and helpers of the video no-signal detector.
// ----------------------------------------------------------------------------
`default_nettype none

package vnsd_pkg;

  // Largest frame dimension; positions saturate at MaxFrameDim - 1
  localparam int unsigned MaxFrameDim = 4096;
  localparam int unsigned PosW        = $clog2(MaxFrameDim);
  localparam logic [PosW-1:0] PosMax  = PosW'(MaxFrameDim - 1);

  localparam int unsigned ColourW = 8;
  localparam int unsigned LfcW    = 15;
  localparam int unsigned CountW  = 16;

  // APB register map, register i at byte address 4*i
  localparam int unsigned AddrW  = 5;
  localparam int unsigned IndexW = 3;
  localparam logic [IndexW-1:0] RegDetectEnable = 3'd0;
  localparam logic [IndexW-1:0] RegDarkColour   = 3'd1;
  localparam logic [IndexW-1:0] RegLostCount    = 3'd2;
  localparam logic [IndexW-1:0] RegWinLeft      = 3'd3;
  localparam logic [IndexW-1:0] RegWinRight     = 3'd4;
  localparam logic [IndexW-1:0] RegWinTop       = 3'd5;
  localparam logic [IndexW-1:0] RegWinBottom    = 3'd6;

  typedef struct packed {
    logic                detect_enable;
    logic [ColourW-1:0]  thr_red;
    logic [ColourW-1:0]  thr_green;
    logic [ColourW-1:0]  thr_blue;
    logic [LfcW-1:0]     lost_frame_count;
    logic [PosW-1:0]     win_left;
    logic [PosW-1:0]     win_right;
    logic [PosW-1:0]     win_top;
    logic [PosW-1:0]     win_bottom;
  } cfg_t;

  // Register image after reset: detection on, loss count 40, the rest zero
  localparam cfg_t CfgReset = '{detect_enable: 1'b1, lost_frame_count: LfcW'(40),
                                default: '0};

  typedef struct packed {
    logic [ColourW-1:0] red;
    logic [ColourW-1:0] green;
    logic [ColourW-1:0] blue;
    logic               line_end;
    logic               frame_end;
  } pix_t;

  // Scan result for the pixel in the input register
  typedef struct packed {
    logic frame_done;
    logic window_dark;
  } scan_ev_t;

  function automatic logic [PosW-1:0] pos_advance(input logic [PosW-1:0] p);
    pos_advance = (p == PosMax) ? PosMax : p + 1'b1;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/vnsd_if.sv
// ----------------------------------------------------------------------------
// vnsd_if
// Valid/ready channels of the detector: pixel stream in, frame verdict out.
// ----------------------------------------------------------------------------
`default_nettype none

interface vnsd_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pix_red;
  logic [7:0] pix_green;
  logic [7:0] pix_blue;
  logic       line_end;
  logic       frame_end;

  modport source (output valid, pix_red, pix_green, pix_blue, line_end, frame_end,
                  input ready);
  modport sink   (input valid, pix_red, pix_green, pix_blue, line_end, frame_end,
                  output ready);
endinterface

interface vnsd_res_if;
  logic valid;
  logic ready;
  logic frame_pass;
  logic signal_lost;
  logic signal_regained;

  modport source (output valid, frame_pass, signal_lost, signal_regained,
                  input ready);
  modport sink   (input valid, frame_pass, signal_lost, signal_regained,
                  output ready);
endinterface

`default_nettype wire

>>> hw/rtl/video_no_signal_detector.sv
// ----------------------------------------------------------------------------
// video_no_signal_detector
// Frame-by-frame dark picture detection on a raster RGB stream.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  pix_i     in   valid/ready          pix_red/green/blue, line_end, frame_end
//  res_o     out  valid/ready          frame_pass, signal_lost, signal_regained
//  apb       in   psel/penable/pwrite  paddr[4:2] = register, pwdata/prdata
//
//  One pixel per cycle sustained unless a frame_end pixel waits on a full
//  result register. An accepted pixel sits in the input register; scan +
//  decision logic loads the result reg behind res_o.valid as it moves on.
//  Only frame_end pixels produce a transaction on res_o.
//  rst_ni zeroes position and dark count, sets the window flag and clears
//  both valid flags; registers come up with detection enabled and a loss
//  count of 40.
//  A stalled verdict only holds back a following frame_end pixel; ordinary
//  pixels keep flowing past it.
// ----------------------------------------------------------------------------
`default_nettype none

module video_no_signal_detector
  import vnsd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  vnsd_pix_if.sink              pix_i,
  vnsd_res_if.source            res_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [31:0]      pwdata,
  output      logic [31:0]      prdata,
  output      logic             pready
);

  cfg_t     cfg;
  pix_t     pix_q;
  logic     in_valid_q, in_valid_d;
  logic     in_accept, adv, res_free;
  scan_ev_t ev;

  vnsd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input register moves on unless a frame verdict is blocked by a full
  // result register.
  assign adv         = in_valid_q && (!pix_q.frame_end || res_free);
  assign pix_i.ready = !in_valid_q || adv;
  assign in_accept   = pix_i.valid && pix_i.ready;
  assign in_valid_d  = in_accept || (in_valid_q && !adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Payload only, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pix_q.red       <= pix_i.pix_red;
      pix_q.green     <= pix_i.pix_green;
      pix_q.blue      <= pix_i.pix_blue;
      pix_q.line_end  <= pix_i.line_end;
      pix_q.frame_end <= pix_i.frame_end;
    end
  end

  vnsd_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .pix_i  (pix_q),
    .adv_i  (adv),
    .ev_o   (ev)
  );

  vnsd_decide u_decide (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .ev_i       (ev),
    .adv_i      (adv),
    .res_free_o (res_free),
    .res        (res_o)
  );

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !adv |=> in_valid_q && $stable(pix_q))
    else $error("held pixel lost while stalled");

endmodule

`default_nettype wire

>>> hw/rtl/vnsd_cfg.sv
// ----------------------------------------------------------------------------
// vnsd_cfg
// APB register file of the detector.
// ----------------------------------------------------------------------------
`default_nettype none

module vnsd_cfg
  import vnsd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [31:0]      pwdata,
  output      logic [31:0]      prdata,
  output      logic             pready,
  output      cfg_t             cfg_o
);

  cfg_t              cfg_q, cfg_d;
  logic              wr_en;
  logic [IndexW-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[AddrW-1:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        RegDetectEnable: cfg_d.detect_enable    = pwdata[0];
        RegDarkColour: begin
          cfg_d.thr_red   = pwdata[23:16];
          cfg_d.thr_green = pwdata[15:8];
          cfg_d.thr_blue  = pwdata[7:0];
        end
        RegLostCount:    cfg_d.lost_frame_count = pwdata[LfcW-1:0];
        RegWinLeft:      cfg_d.win_left         = pwdata[PosW-1:0];
        RegWinRight:     cfg_d.win_right        = pwdata[PosW-1:0];
        RegWinTop:       cfg_d.win_top          = pwdata[PosW-1:0];
        RegWinBottom:    cfg_d.win_bottom       = pwdata[PosW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegDetectEnable: prdata = {31'd0, cfg_q.detect_enable};
      RegDarkColour:   prdata = {8'd0, cfg_q.thr_red, cfg_q.thr_green, cfg_q.thr_blue};
      RegLostCount:    prdata = {{(32-LfcW){1'b0}}, cfg_q.lost_frame_count};
      RegWinLeft:      prdata = {{(32-PosW){1'b0}}, cfg_q.win_left};
      RegWinRight:     prdata = {{(32-PosW){1'b0}}, cfg_q.win_right};
      RegWinTop:       prdata = {{(32-PosW){1'b0}}, cfg_q.win_top};
      RegWinBottom:    prdata = {{(32-PosW){1'b0}}, cfg_q.win_bottom};
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> hw/rtl/vnsd_scan.sv
// ----------------------------------------------------------------------------
// vnsd_scan
// Raster position tracking and window darkness test for each pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module vnsd_scan
  import vnsd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cfg_t     cfg_i,
  input  wire pix_t     pix_i,
  input  wire logic     adv_i,
  output      scan_ev_t ev_o
);

  logic [PosW-1:0] col_q, col_d;
  logic [PosW-1:0] row_q, row_d;
  logic            wdark_q, wdark_d;
  logic            in_window, dark_px, wdark_now;

  assign in_window = (col_q >= cfg_i.win_left) && (col_q < cfg_i.win_right) &&
                     (row_q >= cfg_i.win_top)  && (row_q < cfg_i.win_bottom);
  assign dark_px = (pix_i.red <= cfg_i.thr_red) && (pix_i.green <= cfg_i.thr_green) &&
                   (pix_i.blue <= cfg_i.thr_blue);
  assign wdark_now = wdark_q && !(in_window && !dark_px);

  assign ev_o.frame_done  = pix_i.frame_end;
  assign ev_o.window_dark = wdark_now;

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    wdark_d = wdark_q;
    if (adv_i) begin
      if (pix_i.frame_end) begin
        col_d   = '0;
        row_d   = '0;
        wdark_d = 1'b1;
      end else if (pix_i.line_end) begin
        col_d   = '0;
        row_d   = pos_advance(row_q);
        wdark_d = wdark_now;
      end else begin
        col_d   = pos_advance(col_q);
        wdark_d = wdark_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      wdark_q <= 1'b1;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      wdark_q <= wdark_d;
    end
  end

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && pix_i.frame_end |=> col_q == '0 && row_q == '0 && wdark_q)
    else $error("scan state not restarted after frame end");

endmodule

`default_nettype wire

>>> hw/rtl/vnsd_decide.sv
// ----------------------------------------------------------------------------
// vnsd_decide
// Dark frame counter, per-frame verdict and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module vnsd_decide
  import vnsd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cfg_t        cfg_i,
  input  wire scan_ev_t    ev_i,
  input  wire logic        adv_i,
  output      logic        res_free_o,
  vnsd_res_if.source       res
);

  logic [CountW-1:0] dark_q, dark_d, dark_new, thr;
  logic              fire;
  logic              valid_q, valid_d;
  logic              pass_q, lost_q, regain_q;
  logic              pass_d, lost_d, regain_d;

  assign fire = adv_i && ev_i.frame_done;
  assign thr  = (cfg_i.lost_frame_count == '0) ? CountW'(1)
                                               : CountW'(cfg_i.lost_frame_count);

  always_comb begin
    dark_new = dark_q;
    regain_d = 1'b0;
    if (ev_i.window_dark) begin
      if (dark_q <= thr) dark_new = dark_q + 1'b1;
    end else begin
      regain_d = (dark_q >= thr);
      dark_new = '0;
    end
    pass_d = (dark_new < thr);
    lost_d = (dark_new == thr);
    if (!cfg_i.detect_enable) begin
      dark_new = dark_q;
      pass_d   = 1'b1;
      lost_d   = 1'b0;
      regain_d = 1'b0;
    end
  end

  assign dark_d     = fire ? dark_new : dark_q;
  assign res_free_o = !valid_q || res.ready;
  assign valid_d    = fire || (valid_q && !res.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dark_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      dark_q  <= dark_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      pass_q   <= pass_d;
      lost_q   <= lost_d;
      regain_q <= regain_d;
    end
  end

  assign res.valid           = valid_q;
  assign res.frame_pass      = pass_q;
  assign res.signal_lost     = lost_q;
  assign res.signal_regained = regain_q;

  a_lost_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && lost_q |-> !pass_q)
    else $error("signal lost reported on a forwarded frame");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> !(lost_q && regain_q))
    else $error("lost and regained in the same frame");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> res_free_o)
    else $error("result register overwritten before it was taken");

endmodule

`default_nettype wire
